>>> design/line_clipper_outcode_macros.svh
// Assertion helpers shared by the clipper RTL.
`ifndef LINE_CLIPPER_OUTCODE_MACROS_SVH
`define LINE_CLIPPER_OUTCODE_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define LCO_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define LCO_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/lco_pkg.sv
`default_nettype none

package lco_pkg;

  // Default coordinate width (two's complement)
  localparam int COORD_WIDTH_DEF = 16;

  // Clipping rounds before an undecided segment is dropped
  localparam int ROUND_LIMIT = 8;

  // Window reset values
  localparam int WIN_MIN_RESET = 0;
  localparam int WIN_MAX_RESET = 1023;

  // Region outcode bits
  localparam logic [3:0] CODE_TOP    = 4'h1;
  localparam logic [3:0] CODE_BOTTOM = 4'h2;
  localparam logic [3:0] CODE_RIGHT  = 4'h4;
  localparam logic [3:0] CODE_LEFT   = 4'h8;

  // Window register indexes
  typedef enum logic [1:0] {
    REG_X_MIN = 2'd0,
    REG_Y_MIN = 2'd1,
    REG_X_MAX = 2'd2,
    REG_Y_MAX = 2'd3
  } cfg_idx_e;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } lco_div_sts_t;

endpackage

`default_nettype wire

>>> design/line_clipper_outcode.sv
// Cohen-Sutherland segment clipper. One request carries two signed
// endpoints; the response gives the accepted flag and the clipped endpoints
// (or the original ones when the segment is rejected). A request runs
// through R clipping rounds (0 to 4 for an ordinary window, at most 8), and
// each round uses the shared restoring divider, which produces one quotient
// bit per cycle over a 2*COORD_WIDTH+2 bit dividend. The input is stalled
// from acceptance until the response has been taken, and the next request
// can be accepted in the cycle after that. Window registers are written
// through the configuration port; the user must write them only while the
// block is idle, which the block itself does not enforce. Index 0..3
// selects x_min, y_min, x_max, y_max.
`default_nettype none

`include "line_clipper_outcode_macros.svh"

module line_clipper_outcode
  import lco_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration writes
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic signed [COORD_WIDTH-1:0] cfg_data_i,
  // segment requests
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [COORD_WIDTH-1:0] start_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] start_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] end_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] end_y_i,
  // clipped responses
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               accepted_o,
  output logic signed [COORD_WIDTH-1:0]      clipped_start_x_o,
  output logic signed [COORD_WIDTH-1:0]      clipped_start_y_o,
  output logic signed [COORD_WIDTH-1:0]      clipped_end_x_o,
  output logic signed [COORD_WIDTH-1:0]      clipped_end_y_o
);

  localparam int CW    = COORD_WIDTH;
  localparam int DW    = CW + 1;
  localparam int PW    = 2 * DW;
  localparam int RndW  = $clog2(ROUND_LIMIT + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_MUL    = 6'b000100,
    S_START  = 6'b001000,
    S_DIV    = 6'b010000,
    S_OUT    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic signed [CW-1:0] win_x_min_q, win_y_min_q, win_x_max_q, win_y_max_q;

  // working endpoints and originals
  logic signed [CW-1:0] x0_q, y0_q, x1_q, y1_q;
  logic signed [CW-1:0] x0_d, y0_d, x1_d, y1_d;
  logic signed [CW-1:0] ox0_q, oy0_q, ox1_q, oy1_q;
  logic                 acc_q, acc_d;
  logic [RndW-1:0]      round_q, round_d;

  // operands of the current round
  logic signed [DW-1:0] diff_ba_q, diff_ba_d;
  logic signed [DW-1:0] diff_ec_q, diff_ec_d;
  logic signed [DW-1:0] den_q, den_d;
  logic signed [CW-1:0] base_q, base_d;
  logic signed [CW-1:0] edge_q, edge_d;
  logic                 interp_x_q, interp_x_d;
  logic                 move0_q, move0_d;
  logic signed [PW-1:0] prod_q, prod_d;

  logic [3:0]           code0, code1, sel;
  logic signed [CW-1:0] op_a, op_b, op_c, op_d, op_e;
  logic signed [CW-1:0] new_coord;

  lco_div_sts_t         div_sts;
  logic                 div_start;
  logic signed [PW-1:0] div_quot;

  // outcode of one point against the current window
  function automatic logic [3:0] region(input logic signed [CW-1:0] x,
                                        input logic signed [CW-1:0] y);
    logic [3:0] c;
    c = '0;
    if (y > win_y_max_q) begin
      c = c | CODE_TOP;
    end else if (y < win_y_min_q) begin
      c = c | CODE_BOTTOM;
    end
    if (x > win_x_max_q) begin
      c = c | CODE_RIGHT;
    end else if (x < win_x_min_q) begin
      c = c | CODE_LEFT;
    end
    return c;
  endfunction

  // window registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_x_min_q <= CW'(WIN_MIN_RESET);
      win_y_min_q <= CW'(WIN_MIN_RESET);
      win_x_max_q <= CW'(WIN_MAX_RESET);
      win_y_max_q <= CW'(WIN_MAX_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_X_MIN: win_x_min_q <= cfg_data_i;
        REG_Y_MIN: win_y_min_q <= cfg_data_i;
        REG_X_MAX: win_x_max_q <= cfg_data_i;
        REG_Y_MAX: win_y_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // outcodes and edge choice, top/bottom/right/left priority
  assign code0 = region(x0_q, y0_q);
  assign code1 = region(x1_q, y1_q);
  assign sel   = (code0 != '0) ? code0 : code1;

  always_comb begin
    interp_x_d = 1'b1;
    op_a = x0_q;
    op_b = x1_q;
    op_c = y0_q;
    op_d = y1_q;
    op_e = win_y_max_q;
    if ((sel & CODE_TOP) != '0) begin
      op_e = win_y_max_q;
    end else if ((sel & CODE_BOTTOM) != '0) begin
      op_e = win_y_min_q;
    end else begin
      interp_x_d = 1'b0;
      op_a = y0_q;
      op_b = y1_q;
      op_c = x0_q;
      op_d = x1_q;
      op_e = ((sel & CODE_RIGHT) != '0) ? win_x_max_q : win_x_min_q;
    end
  end

  assign diff_ba_d = DW'(op_b) - DW'(op_a);
  assign diff_ec_d = DW'(op_e) - DW'(op_c);
  assign den_d     = DW'(op_d) - DW'(op_c);
  assign base_d    = op_a;
  assign edge_d    = op_e;
  assign move0_d   = (code0 != '0);

  // single multiplier, registered ahead of the divider
  assign prod_d = diff_ba_q * diff_ec_q;

  assign div_start = (state_q == S_START);

  lco_div #(
    .NUM_W(PW),
    .DEN_W(DW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (prod_q),
    .den_i  (den_q),
    .sts_o  (div_sts),
    .quot_o (div_quot)
  );

  // only the low bits of the interpolated point are kept
  assign new_coord = base_q + div_quot[CW-1:0];

  // sequencer
  always_comb begin
    state_d = state_q;
    x0_d    = x0_q;
    y0_d    = y0_q;
    x1_d    = x1_q;
    y1_d    = y1_q;
    acc_d   = acc_q;
    round_d = round_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          x0_d    = start_x_i;
          y0_d    = start_y_i;
          x1_d    = end_x_i;
          y1_d    = end_y_i;
          round_d = '0;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (code0 == '0 && code1 == '0) begin
          acc_d   = 1'b1;
          state_d = S_OUT;
        end else if ((code0 & code1) != '0 || round_q == RndW'(ROUND_LIMIT)) begin
          // rejected: hand back the request unchanged
          acc_d   = 1'b0;
          x0_d    = ox0_q;
          y0_d    = oy0_q;
          x1_d    = ox1_q;
          y1_d    = oy1_q;
          state_d = S_OUT;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_START;
      end
      S_START: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_sts.done) begin
          if (move0_q) begin
            x0_d = interp_x_q ? new_coord : edge_q;
            y0_d = interp_x_q ? edge_q : new_coord;
          end else begin
            x1_d = interp_x_q ? new_coord : edge_q;
            y1_d = interp_x_q ? edge_q : new_coord;
          end
          round_d = round_q + RndW'(1);
          state_d = S_DECIDE;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      round_q <= '0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    x0_q  <= x0_d;
    y0_q  <= y0_d;
    x1_q  <= x1_d;
    y1_q  <= y1_d;
    acc_q <= acc_d;
    if (state_q == S_IDLE) begin
      ox0_q <= start_x_i;
      oy0_q <= start_y_i;
      ox1_q <= end_x_i;
      oy1_q <= end_y_i;
    end
    if (state_q == S_DECIDE) begin
      diff_ba_q  <= diff_ba_d;
      diff_ec_q  <= diff_ec_d;
      den_q      <= den_d;
      base_q     <= base_d;
      edge_q     <= edge_d;
      interp_x_q <= interp_x_d;
      move0_q    <= move0_d;
    end
    if (state_q == S_MUL) begin
      prod_q <= prod_d;
    end
  end

  // handshake and response
  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = (state_q == S_OUT);
  assign accepted_o        = acc_q;
  assign clipped_start_x_o = x0_q;
  assign clipped_start_y_o = y0_q;
  assign clipped_end_x_o   = x1_q;
  assign clipped_end_y_o   = y1_q;

  `LCO_ASSERT_NXT(a_req_no_early_rsp, clk_i, rst_ni, in_valid_i && !in_stall_o, !out_valid_o,
                  "response in the cycle after a request")
  `LCO_ASSERT_IMP(a_done_in_div, clk_i, rst_ni, div_sts.done, state_q == S_DIV,
                  "divider finished outside the divide state")
  `LCO_ASSERT_IMP(a_div_active, clk_i, rst_ni, state_q == S_DIV, div_sts.busy || div_sts.done,
                  "waiting on an idle divider")
  `LCO_ASSERT_IMP(a_round_bound, clk_i, rst_ni, 1'b1, round_q <= RndW'(ROUND_LIMIT),
                  "round counter past its limit")

endmodule

`default_nettype wire

>>> design/lco_div.sv
`default_nettype none

`include "line_clipper_outcode_macros.svh"

// Radix-2 restoring divider, signed, quotient truncated toward zero.
// One quotient bit per cycle; a zero divisor yields a zero quotient.
module lco_div
  import lco_pkg::*;
#(
  parameter int NUM_W = 2 * COORD_WIDTH_DEF + 2,
  parameter int DEN_W = COORD_WIDTH_DEF + 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [NUM_W-1:0] num_i,
  input  wire logic signed [DEN_W-1:0] den_i,
  output lco_div_sts_t                 sts_o,
  output logic signed [NUM_W-1:0]      quot_o
);

  localparam int CntW = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] qm_q, qm_d;
  logic [DEN_W-1:0] dm_q, dm_d;
  logic             neg_q, neg_d;
  logic             dz_q, dz_d;
  logic signed [NUM_W-1:0] quot_q, quot_d;

  logic [DEN_W:0]   trial;
  logic             fits;

  // one trial subtraction per cycle
  assign trial = {rem_q, qm_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, dm_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    qm_d   = qm_q;
    dm_d   = dm_q;
    neg_d  = neg_q;
    dz_d   = dz_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NUM_W);
      rem_d  = '0;
      qm_d   = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      dm_d   = den_i[DEN_W-1] ? DEN_W'(-den_i) : DEN_W'(den_i);
      neg_d  = num_i[NUM_W-1] ^ den_i[DEN_W-1];
      dz_d   = (den_i == '0);
    end else if (busy_q) begin
      if (fits) begin
        rem_d = DEN_W'(trial - {1'b0, dm_q});
        qm_d  = {qm_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DEN_W-1:0];
        qm_d  = {qm_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        // restore the sign of the truncated quotient
        if (dz_q) begin
          quot_d = '0;
        end else if (neg_q) begin
          quot_d = -$signed(qm_d);
        end else begin
          quot_d = $signed(qm_d);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    qm_q   <= qm_d;
    dm_q   <= dm_d;
    neg_q  <= neg_d;
    dz_q   <= dz_d;
    quot_q <= quot_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quot_o     = quot_q;

  `LCO_ASSERT_NXT(a_div_start_busy, clk_i, rst_ni, start_i, busy_q, "divider idle after start")
  `LCO_ASSERT_IMP(a_div_done_idle, clk_i, rst_ni, done_q, !busy_q, "done while still busy")
  `LCO_ASSERT_IMP(a_div_zero_den, clk_i, rst_ni, done_q && dz_q, quot_q == '0,
                  "zero divisor gave non-zero quotient")

endmodule

`default_nettype wire

>>> test/line_clipper_outcode_test.sv
`default_nettype none

module line_clipper_outcode_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lco_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam longint COORD_LO = -(64'sd1 <<< (CW - 1));
  localparam longint COORD_HI = (64'sd1 <<< (CW - 1)) - 1;

  localparam int IDLE_PCT   = 27;
  localparam int DRAIN_WAIT = 400;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
  } segment_t;

  typedef struct packed {
    logic                 accepted;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
  } clip_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [1:0]    cfg_index = REG_X_MIN;
  logic [CW-1:0] cfg_data = '0;

  logic     in_valid = 1'b0;
  logic     in_stall;
  segment_t drive_seg = '0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 accepted;
  logic signed [CW-1:0] clip_sx, clip_sy, clip_ex, clip_ey;

  // window as the block should currently hold it
  longint win_x_min = WIN_MIN_RESET;
  longint win_y_min = WIN_MIN_RESET;
  longint win_x_max = WIN_MAX_RESET;
  longint win_y_max = WIN_MAX_RESET;

  segment_t pending_segs[$];
  clip_t    expected_clips[$];

  int  n_queued = 0;
  int  n_checked = 0;
  int  n_visible = 0;
  int  n_windows = 1;
  int  errors = 0;
  logic quiet = 1'b0;

  line_clipper_outcode dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .start_x_i         (drive_seg.sx),
    .start_y_i         (drive_seg.sy),
    .end_x_i           (drive_seg.ex),
    .end_y_i           (drive_seg.ey),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .accepted_o        (accepted),
    .clipped_start_x_o (clip_sx),
    .clipped_start_y_o (clip_sy),
    .clipped_end_x_o   (clip_ex),
    .clipped_end_y_o   (clip_ey)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Clipping predictor
  // ---------------------------------------------------------------------------

  function automatic logic [3:0] outcode(longint x, longint y);
    logic [3:0] c;
    c = '0;
    if (y > win_y_max) c |= CODE_TOP;
    else if (y < win_y_min) c |= CODE_BOTTOM;
    if (x > win_x_max) c |= CODE_RIGHT;
    else if (x < win_x_min) c |= CODE_LEFT;
    return c;
  endfunction

  // a + (b - a) * (e - c) / (d - c), quotient truncated toward zero
  function automatic longint edge_cross(longint a, longint b, longint c, longint d,
                                        longint e);
    longint den;
    den = d - c;
    if (den == 0) return a;
    return a + ((b - a) * (e - c)) / den;
  endfunction

  function automatic clip_t clip_segment(segment_t s);
    longint     x0, y0, x1, y1, nx, ny;
    logic [3:0] c0, c1, sel;
    logic       visible;
    clip_t      r;
    x0 = $signed(s.sx);
    y0 = $signed(s.sy);
    x1 = $signed(s.ex);
    y1 = $signed(s.ey);
    c0 = outcode(x0, y0);
    c1 = outcode(x1, y1);
    visible = 1'b0;
    for (int rnd = 0; rnd <= ROUND_LIMIT; rnd++) begin
      if (c0 == '0 && c1 == '0) begin
        visible = 1'b1;
        break;
      end
      if ((c0 & c1) != '0 || rnd == ROUND_LIMIT) break;
      // move the first outside endpoint onto the edge picked by priority
      sel = (c0 != '0) ? c0 : c1;
      if ((sel & CODE_TOP) != '0) begin
        nx = edge_cross(x0, x1, y0, y1, win_y_max);
        ny = win_y_max;
      end else if ((sel & CODE_BOTTOM) != '0) begin
        nx = edge_cross(x0, x1, y0, y1, win_y_min);
        ny = win_y_min;
      end else if ((sel & CODE_RIGHT) != '0) begin
        ny = edge_cross(y0, y1, x0, x1, win_x_max);
        nx = win_x_max;
      end else begin
        ny = edge_cross(y0, y1, x0, x1, win_x_min);
        nx = win_x_min;
      end
      if (c0 != '0) begin
        x0 = nx;
        y0 = ny;
        c0 = outcode(x0, y0);
      end else begin
        x1 = nx;
        y1 = ny;
        c1 = outcode(x1, y1);
      end
    end
    r.accepted = visible;
    if (visible) begin
      r.sx = x0[CW-1:0];
      r.sy = y0[CW-1:0];
      r.ex = x1[CW-1:0];
      r.ey = y1[CW-1:0];
    end else begin
      r.sx = s.sx;
      r.sy = s.sy;
      r.ex = s.ex;
      r.ey = s.ey;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic longint sat(longint v);
    if (v < COORD_LO) return COORD_LO;
    if (v > COORD_HI) return COORD_HI;
    return v;
  endfunction

  function automatic longint rand_coord();
    logic [31:0] r;
    r = $urandom;
    return $signed(r[CW-1:0]);
  endfunction

  // coordinate biased towards the window span [a, b] (either order)
  function automatic longint pick_coord(longint a, longint b);
    longint      lo, hi, margin;
    int unsigned mode;
    mode = $urandom_range(99);
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (mode < 12) return rand_coord();
    if (mode < 20) begin
      case ($urandom_range(3))
        0: return COORD_LO;
        1: return COORD_HI;
        2: return 0;
        default: return -1;
      endcase
    end
    if (mode < 32) begin
      case ($urandom_range(3))
        0: return lo;
        1: return hi;
        2: return sat(lo - 1);
        default: return sat(hi + 1);
      endcase
    end
    margin = (hi - lo) / 2 + 16;
    lo = sat(lo - margin);
    hi = sat(hi + margin);
    return lo + longint'($urandom_range(hi - lo));
  endfunction

  task automatic queue_segment(longint sx, longint sy, longint ex, longint ey);
    segment_t s;
    s.sx = sx[CW-1:0];
    s.sy = sy[CW-1:0];
    s.ex = ex[CW-1:0];
    s.ey = ey[CW-1:0];
    pending_segs.push_back(s);
    n_queued++;
  endtask

  // one register write; valid is left high for a following write
  task automatic write_reg(logic [1:0] idx, longint val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CW-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_X_MIN: win_x_min = val;
      REG_Y_MIN: win_y_min = val;
      REG_X_MAX: win_x_max = val;
      default:   win_y_max = val;
    endcase
  endtask

  // set a window (when asked), then run random segments against it and drain
  task automatic run_phase(logic set_window, longint xmin, longint ymin, longint xmax,
                           longint ymax, int count, logic no_idle);
    if (set_window) begin
      write_reg(REG_X_MIN, xmin);
      write_reg(REG_Y_MIN, ymin);
      write_reg(REG_X_MAX, xmax);
      write_reg(REG_Y_MAX, ymax);
      cfg_valid <= 1'b0;
      n_windows++;
    end
    quiet = no_idle;
    repeat (count) begin
      queue_segment(pick_coord(win_x_min, win_x_max), pick_coord(win_y_min, win_y_max),
                    pick_coord(win_x_min, win_x_max), pick_coord(win_y_min, win_y_max));
    end
    // sender holds off until every outstanding request has been answered
    while (n_checked != n_queued) @(posedge clk);
    quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------

  always @(posedge clk or negedge rst_n) begin : seg_driver
    logic taken;
    logic next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) expected_clips.push_back(clip_segment(drive_seg));
      next_valid = in_valid && !taken;
      if (!next_valid && pending_segs.size() != 0 &&
          (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        drive_seg <= pending_segs.pop_front();
        next_valid = 1'b1;
      end
      in_valid <= next_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Response monitor
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk or negedge rst_n) begin : clip_monitor
    clip_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_clips.size() == 0) begin
          errors++;
          $display("%0t: response with no request outstanding: accepted %0b (%0d,%0d)-(%0d,%0d)",
                   $time, accepted, clip_sx, clip_sy, clip_ex, clip_ey);
        end else begin
          want = expected_clips.pop_front();
          check_field("accepted", want.accepted, accepted);
          check_field("clipped_start_x", $signed(want.sx), clip_sx);
          check_field("clipped_start_y", $signed(want.sy), clip_sy);
          check_field("clipped_end_x", $signed(want.ex), clip_ex);
          check_field("clipped_end_y", $signed(want.ey), clip_ey);
          if (want.accepted) n_visible++;
          n_checked++;
        end
      end
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : main_seq
    longint rx, ry;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed segments against the reset window 0..1023
    queue_segment(10, 10, 1000, 1000);                // fully inside
    queue_segment(COORD_LO, COORD_LO, COORD_HI, COORD_HI);
    queue_segment(COORD_HI, COORD_HI, COORD_LO, COORD_LO);
    queue_segment(-5, 10, -1, 900);                   // both left: trivial reject
    queue_segment(10, 2000, 500, 3000);               // both above: trivial reject
    queue_segment(500, 500, 500, 2000);               // leaves through the top
    queue_segment(500, 500, 500, -2000);              // leaves through the bottom
    queue_segment(500, 500, 5000, 500);               // leaves through the right
    queue_segment(500, 500, -5000, 500);              // leaves through the left
    queue_segment(-100, -100, 1200, 1200);            // crosses both corners
    queue_segment(-200, 900, 200, 1300);              // misses the corner: late reject
    queue_segment(0, 0, 1023, 1023);                  // exactly on the edges
    queue_segment(-1, 0, 1024, 1023);
    queue_segment(2000, 2000, 2000, 2000);            // point outside
    queue_segment(7, 7, 7, 7);                        // point inside
    queue_segment(1023, -5, 1023, 2000);              // vertical on the right edge
    queue_segment(0, COORD_LO, 0, COORD_HI);
    queue_segment(COORD_LO, 0, COORD_HI, 0);
    queue_segment(-1, -1, -1, -1);
    run_phase(1'b0, 0, 0, 0, 0, 140, 1'b0);

    // small centred window, run with no idling on either side
    run_phase(1'b1, -100, -50, 100, 50, 150, 1'b1);
    // whole coordinate range: everything inside
    run_phase(1'b1, COORD_LO, COORD_LO, COORD_HI, COORD_HI, 60, 1'b0);
    // single-point window
    run_phase(1'b1, 5, -7, 5, -7, 100, 1'b0);
    // inverted window: endpoints can bounce between edges up to the round limit
    run_phase(1'b1, 200, 100, -200, -100, 120, 1'b0);
    // windows pushed against the ends of the range
    run_phase(1'b1, COORD_LO, COORD_LO, -32000, -32500, 130, 1'b0);
    run_phase(1'b1, 32000, 32700, COORD_HI, COORD_HI, 130, 1'b0);
    // random ordinary windows
    repeat (3) begin
      rx = rand_coord();
      ry = rand_coord();
      run_phase(1'b1, rx, ry, sat(rx + $urandom_range(3000)), sat(ry + $urandom_range(3000)),
                120, 1'b0);
    end
    // fully random window, possibly inverted
    run_phase(1'b1, rand_coord(), rand_coord(), rand_coord(), rand_coord(), 100, 1'b0);
    // back to the reset window
    run_phase(1'b1, WIN_MIN_RESET, WIN_MIN_RESET, WIN_MAX_RESET, WIN_MAX_RESET, 100, 1'b0);

    // let any stray response show up
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("clipped %0d segments over %0d windows (normal, inverted, point, full range)",
             n_checked, n_windows);
    $display("%0d segments visible, %0d rejected", n_visible, n_checked - n_visible);
    if (errors == 0 && expected_clips.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #50_000_000;
    $display("timeout with %0d of %0d requests answered", n_checked, n_queued);
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
